// ===== design/adip_pkg.sv =====
`default_nettype none

package adip_pkg;

    localparam int unsigned ACC_W       = 64;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned VALUE_TYPE_W = 3;
    localparam int unsigned CFG_DATA_W  = 3;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [VALUE_TYPE_W-1:0] VALUE_TYPE_RST = 3'd3;
    localparam logic                    NULLABLE_RST   = 1'b0;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_TYPE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NULLABLE_MODE = 1'b1;

    // type width codes, value_type[1:0]
    localparam logic [1:0] WIDTH_8  = 2'd0;
    localparam logic [1:0] WIDTH_16 = 2'd1;
    localparam logic [1:0] WIDTH_32 = 2'd2;
    localparam logic [1:0] WIDTH_64 = 2'd3;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [VALUE_TYPE_W-1:0] value_type;
        logic                    nullable_mode;
    } cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] accumulator;
        logic             invalid_seen;
        logic             negative_sign;
    } field_done_t;

    function automatic logic [ACC_W-1:0] width_mask(input logic [1:0] w);
        logic [ACC_W-1:0] m;
        unique case (w)
            WIDTH_8:  m = 64'h0000_0000_0000_00FF;
            WIDTH_16: m = 64'h0000_0000_0000_FFFF;
            WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
            WIDTH_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic top_bit(input logic [ACC_W-1:0] r, input logic [1:0] w);
        logic b;
        unique case (w)
            WIDTH_8:  b = r[7];
            WIDTH_16: b = r[15];
            WIDTH_32: b = r[31];
            WIDTH_64: b = r[63];
            default:  b = r[63];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== design/adip_char_if.sv =====
`default_nettype none

interface adip_char_if;
    import adip_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              last_char;
    logic              empty_field;

    modport source (output valid, output char_byte, output last_char, output empty_field,
                    input ready);
    modport sink (input valid, input char_byte, input last_char, input empty_field,
                  output ready);
endinterface

`default_nettype wire

// ===== design/adip_result_if.sv =====
`default_nettype none

interface adip_result_if;
    import adip_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACC_W-1:0] field_value;
    logic             is_null;

    modport source (output valid, output field_value, output is_null, input ready);
    modport sink (input valid, input field_value, input is_null, output ready);
endinterface

`default_nettype wire

// ===== design/adip_accum.sv =====
`default_nettype none

module adip_accum (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    adip_char_if.sink                 chars,
    input  wire adip_pkg::cfg_t       cfg,
    output logic                      done_valid,
    input  wire logic                 done_ready,
    output adip_pkg::field_done_t     done_data
);
    import adip_pkg::*;

    // input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              in_empty_reg;

    // field state
    logic [ACC_W-1:0]  acc_reg;
    logic              invalid_reg;
    logic              negative_reg;
    logic              at_start_reg;

    // finished field register
    logic              done_valid_reg;
    field_done_t       done_reg;

    logic              is_signed;
    logic [ACC_W-1:0]  mask;
    logic              is_digit;
    logic              is_sign;
    logic [3:0]        digit;
    logic [ACC_W-1:0]  times_ten;
    logic [ACC_W-1:0]  acc_next;
    logic              invalid_next;
    logic              negative_next;
    logic              field_end;
    logic              done_free;
    logic              step;
    logic              in_load;

    always_comb
    begin
        is_signed = ~cfg.value_type[2];
        mask      = width_mask(cfg.value_type[1:0]);
        is_digit  = (in_char_reg >= CH_ZERO) && (in_char_reg <= CH_NINE);
        is_sign   = at_start_reg && is_signed
                    && ((in_char_reg == CH_MINUS) || (in_char_reg == CH_PLUS));
        digit     = 4'(in_char_reg - CH_ZERO);
        // acc * 10 as acc * 8 + acc * 2
        times_ten = {acc_reg[ACC_W-4:0], 3'b000} + {acc_reg[ACC_W-2:0], 1'b0};

        acc_next      = acc_reg;
        invalid_next  = invalid_reg;
        negative_next = negative_reg;
        if (in_empty_reg)
        begin
            invalid_next = 1'b1;
        end
        else if (is_sign)
        begin
            negative_next = (in_char_reg == CH_MINUS);
        end
        else if (is_digit)
        begin
            acc_next = times_ten + ACC_W'(digit);
        end
        else
        begin
            invalid_next = 1'b1;
        end
        // narrow unsigned range check; the mask is all ones for 64 bits
        if (cfg.value_type[2] && ((acc_next & ~mask) != '0))
        begin
            invalid_next = 1'b1;
        end

        field_end = in_empty_reg || in_last_reg;
        done_free = ~done_valid_reg || done_ready;
        step      = in_valid_reg && (~field_end || done_free);
        in_load   = chars.valid && chars.ready;
    end

    assign chars.ready = ~in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_char_reg  <= chars.char_byte;
            in_last_reg  <= chars.last_char;
            in_empty_reg <= chars.empty_field;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            invalid_reg  <= 1'b0;
            negative_reg <= 1'b0;
            at_start_reg <= 1'b1;
        end
        else if (step)
        begin
            if (field_end)
            begin
                acc_reg      <= '0;
                invalid_reg  <= 1'b0;
                negative_reg <= 1'b0;
                at_start_reg <= 1'b1;
            end
            else
            begin
                acc_reg      <= acc_next;
                invalid_reg  <= invalid_next;
                negative_reg <= negative_next;
                at_start_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_valid_reg <= 1'b0;
        end
        else if (step && field_end)
        begin
            done_valid_reg <= 1'b1;
        end
        else if (done_ready)
        begin
            done_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && field_end)
        begin
            done_reg.accumulator   <= acc_next;
            done_reg.invalid_seen  <= invalid_next;
            done_reg.negative_sign <= negative_next;
        end
    end

    assign done_valid = done_valid_reg;
    assign done_data  = done_reg;

endmodule

`default_nettype wire

// ===== design/adip_format.sv =====
`default_nettype none

module adip_format (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire adip_pkg::cfg_t       cfg,
    input  wire logic                 done_valid,
    output logic                      done_ready,
    input  wire adip_pkg::field_done_t done_data,
    adip_result_if.source             results
);
    import adip_pkg::*;

    logic             out_valid_reg;
    logic [ACC_W-1:0] field_value_reg;
    logic             is_null_reg;

    logic [ACC_W-1:0] mask;
    logic [ACC_W-1:0] signed_val;
    logic [ACC_W-1:0] value_next;
    logic             is_null_next;
    logic             out_free;

    always_comb
    begin
        mask       = width_mask(cfg.value_type[1:0]);
        signed_val = done_data.negative_sign ? (ACC_W'(0) - done_data.accumulator)
                                             : done_data.accumulator;
        signed_val = signed_val & mask;
        // sign-extend from the type's top bit
        if (top_bit(signed_val, cfg.value_type[1:0]))
        begin
            signed_val = signed_val | ~mask;
        end

        if (done_data.invalid_seen)
        begin
            value_next = '0;
        end
        else if (!cfg.value_type[2])
        begin
            value_next = signed_val;
        end
        else
        begin
            value_next = done_data.accumulator & mask;
        end
        is_null_next = cfg.nullable_mode && done_data.invalid_seen;
        out_free     = ~out_valid_reg || results.ready;
    end

    assign done_ready = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_valid && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && out_free)
        begin
            field_value_reg <= value_next;
            is_null_reg     <= is_null_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.field_value = field_value_reg;
    assign results.is_null     = is_null_reg;

endmodule

`default_nettype wire

// ===== design/ascii_decimal_int_parser.sv =====
`default_nettype none

// Decimal text to integer parser. Each beat on chars carries one ASCII character of a
// field; a beat with last_char or empty_field closes the field and one beat follows on
// results with the value in the type chosen by value_type (int8..int64, uint8..uint64),
// sign- or zero-extended to 64 bits, and is_null set for an invalid field in nullable
// mode. One character is taken every clock cycle unless a closing character waits for
// the previous field to leave the field register; the multiply-by-ten and add of the
// 64-bit accumulator is combinational, which sets that rate. A closed field moves from
// the input register to the field register, then the result register; sign negation
// and range masking sit in the last stage. Configuration writes are taken at any time
// but must only be made while no field is in flight.
module ascii_decimal_int_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    adip_char_if.sink                              chars,
    adip_result_if.source                          results,
    input  wire logic                              cfg_we,
    input  wire logic [adip_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [adip_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adip_pkg::*;

    logic [VALUE_TYPE_W-1:0] value_type_reg;
    logic                    nullable_mode_reg;
    cfg_t                    cfg;
    logic                    done_valid;
    logic                    done_ready;
    field_done_t             done_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_type_reg    <= VALUE_TYPE_RST;
            nullable_mode_reg <= NULLABLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VALUE_TYPE:    value_type_reg    <= cfg_data[VALUE_TYPE_W-1:0];
                CFG_NULLABLE_MODE: nullable_mode_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg.value_type    = value_type_reg;
    assign cfg.nullable_mode = nullable_mode_reg;

    adip_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .cfg        (cfg),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_data  (done_data)
    );

    adip_format u_format (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .done_valid (done_valid),
        .done_ready (done_ready),
        .done_data  (done_data),
        .results    (results)
    );

    // an invalid field always reads back as zero
    a_null_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.is_null |-> results.field_value == '0)
        else $error("null result with nonzero value");

    a_null_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.is_null |-> nullable_mode_reg)
        else $error("null result outside nullable mode");

    // unsigned results never exceed the type width
    a_unsigned_fits: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && value_type_reg[2]
        |-> (results.field_value & ~width_mask(value_type_reg[1:0])) == '0)
        else $error("unsigned result wider than its type");

endmodule

`default_nettype wire
